@@ design/hasmp_pkg.sv @@
// Package for the hashed address set: command and status codes, hash constants,
// and the transaction structs. No dependencies.
package hasmp_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;
    localparam logic [1:0] CMD_POP    = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // Only the low 16 bits of the hash can reach a bucket index.
    localparam logic [15:0] HASH_MUL_LO = 16'(32'd1103515245);
    localparam logic [15:0] HASH_ADD_LO = 16'(32'd12345);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] popped_value;
        logic        set_empty;
    } t_out;

endpackage

@@ design/hashed_address_set_with_min_pop_unit.sv @@
// Top level of the hashed address set with remove-smallest.
// Depends on hasmp_pkg and hasmp_mem.
//
// Usage:
//   Input channel: drive i_item (cmd, address) and raise start while busy is
//   low; the transaction is taken at that clock edge and busy rises.
//   Output channel: each command gives one result on o_result, marked by
//   o_done for exactly one cycle. The receiver cannot stall; take it then.
//   Storage: BUCKETS*WAYS slots in one memory word each {valid, address}.
//   The bucket is the low bits of address*1103515245+12345, masked by
//   BUCKETS-1. A shared read port and one compare unit walk the slots.
// Sequence (start accepted to o_done):
//   insert, delete, test: hash, base, WAYS bucket reads, draining the last
//   read, finish/write, then the result.
//   remove smallest: the same steps, but the scan reads every slot in turn
//   through the single memory read port.
//   Throughput: one command at a time; busy stays high until the result.
// Reset: a clearing pass writes every slot invalid with busy high;
//   the held count returns to zero.
module hashed_address_set_with_min_pop_unit #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hasmp_pkg::t_in    i_item,
    output logic              busy,
    output logic              o_done,
    output hasmp_pkg::t_out   o_result
);
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_BASE, S_SCAN, S_FINISH
    } t_state;

    t_state        r_state;
    logic [1:0]    r_cmd;
    logic [63:0]   r_addr;
    logic [BW-1:0] r_bucket;
    logic [SW-1:0] r_rd_addr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_held;
    logic          r_pv;
    logic [SW-1:0] r_pidx;
    logic          r_hit;
    logic [SW-1:0] r_hit_idx;
    logic          r_free;
    logic [SW-1:0] r_free_idx;
    logic [63:0]   r_best;
    logic [SW-1:0] r_best_idx;

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [64:0]   mem_wdata;
    logic          mem_re;
    logic [64:0]   mem_rdata;
    logic [15:0]   hash_lo;
    logic [CW-1:0] scan_len;
    logic          rd_valid;
    logic [63:0]   rd_addr;

    hasmp_mem #(.DEPTH(SLOTS), .AW(SW), .DW(65)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_addr),
        .o_rdata (mem_rdata)
    );

    assign hash_lo  = i_item.address[15:0] * hasmp_pkg::HASH_MUL_LO + hasmp_pkg::HASH_ADD_LO;
    assign scan_len = (r_cmd == hasmp_pkg::CMD_POP) ? CW'(SLOTS) : CW'(WAYS);
    assign rd_valid = mem_rdata[64];
    assign rd_addr  = mem_rdata[63:0];
    assign busy     = (r_state != S_IDLE);
    assign mem_re   = (r_state == S_SCAN) && (r_cnt != scan_len);

    // Write port: clearing pass, or at most one update at the end of a command.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_addr;
        mem_wdata = 65'd0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_FINISH) begin
            unique case (r_cmd)
                hasmp_pkg::CMD_INSERT: begin
                    mem_we    = !r_hit && r_free;
                    mem_waddr = r_free_idx;
                    mem_wdata = {1'b1, r_addr};
                end
                hasmp_pkg::CMD_DELETE: begin
                    mem_we    = r_hit;
                    mem_waddr = r_hit_idx;
                end
                hasmp_pkg::CMD_TEST: begin
                    mem_we = 1'b0;
                end
                hasmp_pkg::CMD_POP: begin
                    mem_we    = r_free;
                    mem_waddr = r_best_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rd_addr <= '0;
            r_cnt     <= '0;
            r_held    <= '0;
            r_pv      <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // Sweep every slot to invalid.
                    r_rd_addr <= r_rd_addr + 1'b1;
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_item.cmd;
                        r_addr   <= i_item.address;
                        r_bucket <= BW'(hash_lo & 16'(BUCKETS - 1));
                        r_state  <= S_HASH;
                    end
                end
                S_HASH: begin
                    // Bucket base slot; remove smallest walks the whole store.
                    r_rd_addr <= (r_cmd == hasmp_pkg::CMD_POP) ? '0
                                                                : SW'(r_bucket * WAYS);
                    r_state   <= S_BASE;
                end
                S_BASE: begin
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_hit   <= 1'b0;
                    r_free  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Issue one read a cycle, evaluate the previous read.
                    if (mem_re) begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                        r_cnt     <= r_cnt + 1'b1;
                        r_pidx    <= r_rd_addr;
                    end
                    r_pv <= mem_re;
                    if (r_pv) begin
                        if (r_cmd == hasmp_pkg::CMD_POP) begin
                            // r_free marks "some valid entry seen" here.
                            if (rd_valid && (!r_free || rd_addr < r_best)) begin
                                r_free     <= 1'b1;
                                r_best     <= rd_addr;
                                r_best_idx <= r_pidx;
                            end
                        end else begin
                            if (rd_valid && rd_addr == r_addr) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_pidx;
                            end
                            if (!rd_valid && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_pidx;
                            end
                        end
                    end
                    if (!mem_re && !r_pv) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    o_done                <= 1'b1;
                    o_result.found        <= 1'b0;
                    o_result.popped_value <= 64'd0;
                    o_result.status       <= hasmp_pkg::ST_DONE;
                    o_result.set_empty    <= (r_held == '0);
                    unique case (r_cmd)
                        hasmp_pkg::CMD_INSERT: begin
                            if (r_hit) begin
                                o_result.status <= hasmp_pkg::ST_PRESENT;
                            end else if (!r_free) begin
                                o_result.status <= hasmp_pkg::ST_FULL;
                            end else begin
                                r_held             <= r_held + 1'b1;
                                o_result.set_empty <= 1'b0;
                            end
                        end
                        hasmp_pkg::CMD_DELETE, hasmp_pkg::CMD_TEST: begin
                            if (!r_hit) begin
                                o_result.status <= hasmp_pkg::ST_ABSENT;
                            end else begin
                                o_result.found <= 1'b1;
                                if (r_cmd == hasmp_pkg::CMD_DELETE) begin
                                    r_held             <= r_held - 1'b1;
                                    o_result.set_empty <= (r_held == CW'(1));
                                end
                            end
                        end
                        hasmp_pkg::CMD_POP: begin
                            if (!r_free) begin
                                o_result.status <= hasmp_pkg::ST_EMPTY;
                            end else begin
                                o_result.popped_value <= r_best;
                                r_held                <= r_held - 1'b1;
                                o_result.set_empty    <= (r_held == CW'(1));
                            end
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/hasmp_mem.sv @@
// Slot store: one write port, one read port with registered read data.
// No package dependencies.
module hasmp_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 65
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for hashed_address_set_with_min_pop_unit.
// Depends on hasmp_pkg and the unit's RTL; predicts each result with a local set model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = 256;
    localparam int WAYS = 4;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int LIMIT = 6_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    hasmp_pkg::t_in i_item = '0;
    logic busy;
    logic o_done;
    hasmp_pkg::t_out o_result;

    hashed_address_set_with_min_pop_unit #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_done(o_done), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the set contents, updated as each transaction is accepted.
    bit set_valid [SLOTS];
    logic [63:0] set_addr [SLOTS];
    int unsigned held;
    hasmp_pkg::t_out pending_results [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    logic [63:0] inserted [$];   // addresses likely held, to aim deletes and tests

    function automatic int unsigned bucket_base(logic [63:0] a);
        logic [63:0] h;
        h = a * 64'd1103515245 + 64'd12345;
        return int'(h & 64'(BUCKETS - 1)) * WAYS;
    endfunction

    function automatic int find_addr(logic [63:0] a);
        int unsigned b;
        b = bucket_base(a);
        for (int w = 0; w < WAYS; w++)
            if (set_valid[b + w] && set_addr[b + w] == a) return b + w;
        return -1;
    endfunction

    // Apply one command to the mirror and return the result it must give.
    function automatic hasmp_pkg::t_out apply_cmd(hasmp_pkg::t_in it);
        hasmp_pkg::t_out r;
        int s;
        int unsigned b;
        int best;
        r = '0;
        r.status = hasmp_pkg::ST_DONE;
        case (it.cmd)
            hasmp_pkg::CMD_INSERT: begin
                if (find_addr(it.address) >= 0) begin
                    r.status = hasmp_pkg::ST_PRESENT;
                end else begin
                    b = bucket_base(it.address);
                    r.status = hasmp_pkg::ST_FULL;
                    for (int w = 0; w < WAYS; w++) begin
                        if (!set_valid[b + w]) begin
                            set_valid[b + w] = 1'b1;
                            set_addr[b + w] = it.address;
                            held++;
                            r.status = hasmp_pkg::ST_DONE;
                            break;
                        end
                    end
                end
            end
            hasmp_pkg::CMD_DELETE, hasmp_pkg::CMD_TEST: begin
                s = find_addr(it.address);
                if (s < 0) begin
                    r.status = hasmp_pkg::ST_ABSENT;
                end else begin
                    r.found = 1'b1;
                    if (it.cmd == hasmp_pkg::CMD_DELETE) begin
                        set_valid[s] = 1'b0;
                        if (held > 0) held--;
                    end
                end
            end
            default: begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (set_valid[i] && (best < 0 || set_addr[i] < set_addr[best])) best = i;
                if (best < 0) begin
                    r.status = hasmp_pkg::ST_EMPTY;
                end else begin
                    r.popped_value = set_addr[best];
                    set_valid[best] = 1'b0;
                    if (held > 0) held--;
                end
            end
        endcase
        r.set_empty = (held == 0);
        return r;
    endfunction

    // Compare each strobed result against the oldest pending prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending");
                errors++;
            end else begin
                hasmp_pkg::t_out e;
                e = pending_results.pop_front();
                if (o_result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_result.status);
                    errors++;
                end
                if (o_result.found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_result.found);
                    errors++;
                end
                if (o_result.popped_value !== e.popped_value) begin
                    $error("popped_value exp %h got %h", e.popped_value,
                           o_result.popped_value);
                    errors++;
                end
                if (o_result.set_empty !== e.set_empty) begin
                    $error("set_empty exp %0d got %0d", e.set_empty, o_result.set_empty);
                    errors++;
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("FAIL hashed_address_set_with_min_pop_unit");
            $finish;
        end
    end

    // Hold a random gap, mostly short and occasionally long; drop start meanwhile.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Send one transaction; prediction is made at the accepting edge.
    // Start stays high after acceptance so the next transaction can follow at once.
    task automatic send_cmd(logic [1:0] c, logic [63:0] a, bit gaps = 1'b1);
        hasmp_pkg::t_in it;
        it.cmd = c;
        it.address = a;
        if (gaps) idle_gap();
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // This edge accepts the transaction.
        pending_results.push_back(apply_cmd(it));
        if (c == hasmp_pkg::CMD_INSERT) inserted.push_back(a);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
    endtask

    // Addresses sharing a bucket: stepping by BUCKETS keeps the low hash bits.
    task automatic test_directed();
        send_cmd(hasmp_pkg::CMD_POP, 64'h0, 1'b0);       // remove smallest on empty set
        send_cmd(hasmp_pkg::CMD_TEST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_cmd(hasmp_pkg::CMD_DELETE, 64'h0, 1'b0);
        send_cmd(hasmp_pkg::CMD_INSERT, 64'h0, 1'b0);
        send_cmd(hasmp_pkg::CMD_INSERT, 64'h0, 1'b0);    // duplicate
        send_cmd(hasmp_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_cmd(hasmp_pkg::CMD_TEST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        for (int k = 1; k <= WAYS; k++)                  // fill one bucket, then overflow
            send_cmd(hasmp_pkg::CMD_INSERT, 64'(k * BUCKETS), 1'b0);
        send_cmd(hasmp_pkg::CMD_INSERT, 64'(BUCKETS), 1'b0);  // duplicate before full check
        send_cmd(hasmp_pkg::CMD_DELETE, 64'(2 * BUCKETS), 1'b0);
        send_cmd(hasmp_pkg::CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 1'b0);
        for (int k = 0; k < WAYS + 3; k++)               // pop down through the all-ones
            send_cmd(hasmp_pkg::CMD_POP, 64'hAAAA_5555_AAAA_5555, 1'b0);
        drain_results();
    endtask

    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 31)) * BUCKETS; // crowd one bucket
            2: return (inserted.size() > 0) ?
                      inserted[$urandom_range(0, inserted.size() - 1)] : 64'h0;
            default: return ~64'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_random();
        int r;
        for (int n = 0; n < 1000; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) send_cmd(hasmp_pkg::CMD_INSERT, pick_addr());
            else if (r < 65) send_cmd(hasmp_pkg::CMD_DELETE, pick_addr());
            else if (r < 90) send_cmd(hasmp_pkg::CMD_TEST, pick_addr());
            else send_cmd(hasmp_pkg::CMD_POP, {$urandom, $urandom});
            if (n == 500) drain_results();   // pause until all results are in
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            set_valid[i] = 1'b0;
            set_addr[i] = '0;
        end
        held = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (errors == 0) begin
            $display("PASS hashed_address_set_with_min_pop_unit");
        end else begin
            $display("FAIL hashed_address_set_with_min_pop_unit");
        end
        $finish;
    end
endmodule
